// File: sv/fpr_pkg.sv
// shared constants, types and helper functions of the framed packet receiver
package fpr_pkg;

  // sizing of the packet store
  localparam int NUM_TYPES  = 4;
  localparam int MAX_LEN    = 32;
  localparam int NUM_LANES  = 4;
  localparam int LANE_W     = 8;
  localparam int STORE_SIZE = NUM_TYPES * MAX_LEN;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int LEN_W      = $clog2(MAX_LEN + 1);
  localparam int MATCH_N    = (NUM_TYPES < NUM_LANES) ? NUM_TYPES : NUM_LANES;
  localparam int POS_MAX    = 31;

  // frame characters and register reset values
  localparam logic [7:0] CHAR_L = 8'h4C;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_E = 8'h45;
  localparam logic [7:0] LEN0_RST = 8'd20;
  localparam logic [7:0] LEN1_RST = 8'd15;
  localparam logic [31:0] HEADER_RST = {16'h0000, CHAR_C, CHAR_L};
  localparam logic [31:0] TAIL_RST   = {16'h0000, CHAR_E, CHAR_E};
  localparam logic [31:0] LENGTH_RST = {16'h0000, LEN1_RST, LEN0_RST};
  localparam logic [3:0]  ENABLE_RST = 4'h3;

  // result status codes
  typedef enum logic [2:0] {
    RES_NO_MATCH = 3'd0,
    RES_HEADER   = 3'd1,
    RES_STORED   = 3'd2,
    RES_DROPPED  = 3'd3,
    RES_FINISHED = 3'd4,
    RES_READ     = 3'd5
  } res_status_e;

  // transaction modes
  typedef enum logic {
    MODE_RX   = 1'b0,
    MODE_READ = 1'b1
  } mode_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_HEADER  = 2'd0,
    CFG_TAIL    = 2'd1,
    CFG_LENGTHS = 2'd2,
    CFG_ENABLE  = 2'd3
  } cfg_reg_e;

  // receive state
  typedef enum logic {
    RX_IDLE = 1'b0,
    RX_BUSY = 1'b1
  } rx_state_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] byte_value;
    logic [1:0] read_type;
    logic [4:0] read_position;
    logic       clear_finished;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] type_index;
    logic [4:0] position;
    logic [7:0] data_byte;
    logic [3:0] finished_mask;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [31:0] header_chars;
    logic [31:0] tail_chars;
    logic [31:0] type_lengths;
    logic [3:0]  type_enable;
  } cfg_t;

  // request bundle from the control logic to the packet store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              clr;
    logic [1:0]        clr_row;
    logic [LEN_W-1:0]  clr_len;
  } store_req_t;

  // one byte lane of a configuration register
  function automatic logic [7:0] lane_byte(logic [31:0] r, logic [1:0] t);
    return r[LANE_W*t +: LANE_W];
  endfunction

  // buffer length of a type, limited to the row size
  function automatic logic [LEN_W-1:0] type_len(logic [31:0] lens, logic [1:0] t);
    logic [7:0] n;
    n = lane_byte(lens, t);
    if (int'(n) > MAX_LEN) begin
      return LEN_W'(MAX_LEN);
    end
    return LEN_W'(n);
  endfunction

  // byte count reported in the position field
  function automatic logic [4:0] sat_pos(logic [LEN_W-1:0] w);
    if (int'(w) > POS_MAX) begin
      return 5'(POS_MAX);
    end
    return 5'(w);
  endfunction

  // store address of a position within a type's row
  function automatic logic [ADDR_W-1:0] store_addr(logic [1:0] t, logic [LEN_W-1:0] p);
    return ADDR_W'(int'(t) * MAX_LEN + int'(p));
  endfunction

endpackage

// File: sv/fpr_if.sv
// handshake channel interfaces of the framed packet receiver

// input item channel
interface fpr_in_if;
  logic               valid;
  logic               ready;
  fpr_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// result item channel
interface fpr_out_if;
  logic               valid;
  logic               ready;
  fpr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// configuration write channel
interface fpr_cfg_if;
  logic             valid;
  logic             ready;
  fpr_pkg::cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/fpr_cfg.sv
// configuration registers of the framed packet receiver
module fpr_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  fpr_cfg_if.sink       cfg_i,
  output fpr_pkg::cfg_t cfg_o
);

  fpr_pkg::cfg_t cfg_q;
  fpr_pkg::cfg_t cfg_d;

  // writes are always taken
  assign cfg_i.ready = 1'b1;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (fpr_pkg::cfg_reg_e'(cfg_i.data.index))
        fpr_pkg::CFG_HEADER:  cfg_d.header_chars = cfg_i.data.wdata;
        fpr_pkg::CFG_TAIL:    cfg_d.tail_chars   = cfg_i.data.wdata;
        fpr_pkg::CFG_LENGTHS: cfg_d.type_lengths = cfg_i.data.wdata;
        fpr_pkg::CFG_ENABLE:  cfg_d.type_enable  = cfg_i.data.wdata[3:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_chars <= fpr_pkg::HEADER_RST;
      cfg_q.tail_chars   <= fpr_pkg::TAIL_RST;
      cfg_q.type_lengths <= fpr_pkg::LENGTH_RST;
      cfg_q.type_enable  <= fpr_pkg::ENABLE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/fpr_store.sv
// packet store: byte memory with per-entry valid bits and a registered read
module fpr_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fpr_pkg::store_req_t req_i,
  output logic [7:0]          rdata_o
);

  logic [7:0]                       mem_q [fpr_pkg::STORE_SIZE];
  logic [fpr_pkg::STORE_SIZE-1:0]   vld_q;
  logic [fpr_pkg::STORE_SIZE-1:0]   vld_d;
  logic [7:0]                       rd_q;
  logic                             rd_vld_q;

  // byte array, one write and one read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q     <= mem_q[req_i.raddr];
      rd_vld_q <= vld_q[req_i.raddr];
    end
  end

  // valid bits: a header wipes the leading part of its row, a write sets one entry
  always_comb begin
    vld_d = vld_q;
    for (int i = 0; i < fpr_pkg::STORE_SIZE; i++) begin
      if (req_i.clr && (int'(req_i.clr_row) == i / fpr_pkg::MAX_LEN) &&
          (i % fpr_pkg::MAX_LEN < int'(req_i.clr_len))) begin
        vld_d[i] = 1'b0;
      end
      if (req_i.we && (int'(req_i.waddr) == i)) begin
        vld_d[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // entries never written since their row was wiped read as zero
  assign rdata_o = rd_vld_q ? rd_q : 8'h00;

endmodule

// File: sv/framed_packet_receiver_unit.sv
// Framed packet receiver: takes one transaction per clock cycle while the output is not
// stalled, received bytes and read requests alike, and returns exactly one result per
// transaction after it passes the read stage (the registered read of the packet store)
// and the output register. The rate is set by the packet store, which sees at most one
// write or one read per transaction; forwarding is not needed since every access
// completes at its own accept edge. Header matching over the enabled types is done in
// parallel in the accept cycle. The store needs no clearing pass after reset: each entry
// carries a valid bit that reset clears, so unwritten bytes read as zero at once.
module framed_packet_receiver_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  fpr_in_if.sink     in_i,
  fpr_out_if.source  out_o,
  fpr_cfg_if.sink    cfg_i
);

  fpr_pkg::cfg_t              cfg;
  fpr_pkg::store_req_t        req;
  logic [7:0]                 store_rdata;

  fpr_pkg::rx_state_e         state_q, state_d;
  logic [1:0]                 cur_type_q, cur_type_d;
  logic [fpr_pkg::LEN_W-1:0]  wpos_q, wpos_d;
  logic [3:0]                 fin_q, fin_d;

  fpr_pkg::out_item_t         res;
  logic                       rd_ok;
  logic                       is_read;

  logic                       s1_vld_q;
  fpr_pkg::out_item_t         s1_q;
  logic                       s1_read_q;
  logic                       s1_rd_ok_q;
  fpr_pkg::out_item_t         s1_out;
  logic                       s1_adv;

  logic                       out_vld_q;
  fpr_pkg::out_item_t         out_q;

  logic                       acc;
  fpr_pkg::in_item_t          item;
  logic                       hit;
  logic [1:0]                 hit_t;
  logic                       tail_hit;
  logic [fpr_pkg::LEN_W-1:0]  cur_len;

  fpr_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  fpr_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rdata_o (store_rdata)
  );

  // handshake
  assign s1_adv     = !out_vld_q || out_o.ready;
  assign in_i.ready = !s1_vld_q || s1_adv;
  assign acc        = in_i.valid && in_i.ready;
  assign item       = in_i.data;

  // header match, lowest enabled type wins
  always_comb begin
    hit   = 1'b0;
    hit_t = '0;
    for (int t = fpr_pkg::MATCH_N - 1; t >= 0; t--) begin
      if (cfg.type_enable[t] &&
          (fpr_pkg::lane_byte(cfg.header_chars, 2'(t)) == item.byte_value)) begin
        hit   = 1'b1;
        hit_t = 2'(t);
      end
    end
  end

  assign tail_hit = fpr_pkg::lane_byte(cfg.tail_chars, cur_type_q) == item.byte_value;
  assign cur_len  = fpr_pkg::type_len(cfg.type_lengths, cur_type_q);

  // receive state: next state
  always_comb begin
    state_d = state_q;
    if (acc && (item.mode == fpr_pkg::MODE_RX)) begin
      case (state_q)
        fpr_pkg::RX_IDLE: if (hit) state_d = fpr_pkg::RX_BUSY;
        fpr_pkg::RX_BUSY: if (tail_hit) state_d = fpr_pkg::RX_IDLE;
        default: state_d = fpr_pkg::RX_IDLE;
      endcase
    end
  end

  // receive state: outputs, store requests and result
  always_comb begin
    fin_d      = fin_q;
    cur_type_d = cur_type_q;
    wpos_d     = wpos_q;
    req        = '0;
    rd_ok      = 1'b0;
    is_read    = 1'b0;
    res        = '0;
    res.status    = fpr_pkg::RES_NO_MATCH;
    res.data_byte = item.byte_value;
    if (acc) begin
      if (item.mode == fpr_pkg::MODE_READ) begin
        is_read        = 1'b1;
        res.status     = fpr_pkg::RES_READ;
        res.type_index = item.read_type;
        res.position   = item.read_position;
        res.data_byte  = 8'h00;
        if (int'(item.read_type) < fpr_pkg::NUM_TYPES) begin
          if (int'(item.read_position) < fpr_pkg::MAX_LEN) begin
            rd_ok     = 1'b1;
            req.re    = 1'b1;
            req.raddr = fpr_pkg::store_addr(item.read_type,
                                            fpr_pkg::LEN_W'(item.read_position));
          end
          if (item.clear_finished) begin
            fin_d[item.read_type] = 1'b0;
          end
        end
      end else begin
        case (state_q)
          fpr_pkg::RX_IDLE: begin
            if (hit) begin
              req.clr        = 1'b1;
              req.clr_row    = hit_t;
              req.clr_len    = fpr_pkg::type_len(cfg.type_lengths, hit_t);
              fin_d[hit_t]   = 1'b0;
              cur_type_d     = hit_t;
              wpos_d         = '0;
              res.status     = fpr_pkg::RES_HEADER;
              res.type_index = hit_t;
            end
          end
          fpr_pkg::RX_BUSY: begin
            res.type_index = cur_type_q;
            if (tail_hit) begin
              res.status        = fpr_pkg::RES_FINISHED;
              res.position      = fpr_pkg::sat_pos(wpos_q);
              fin_d[cur_type_q] = 1'b1;
              wpos_d            = '0;
            end else if (wpos_q < cur_len) begin
              req.we       = 1'b1;
              req.waddr    = fpr_pkg::store_addr(cur_type_q, wpos_q);
              req.wdata    = item.byte_value;
              res.status   = fpr_pkg::RES_STORED;
              res.position = 5'(wpos_q);
              wpos_d       = wpos_q + 1'b1;
            end else begin
              res.status   = fpr_pkg::RES_DROPPED;
              res.position = fpr_pkg::sat_pos(wpos_q);
            end
          end
          default: res.status = fpr_pkg::RES_NO_MATCH;
        endcase
      end
    end
    res.finished_mask = fin_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= fpr_pkg::RX_IDLE;
      cur_type_q <= '0;
      wpos_q     <= '0;
      fin_q      <= '0;
    end else begin
      state_q    <= state_d;
      cur_type_q <= cur_type_d;
      wpos_q     <= wpos_d;
      fin_q      <= fin_d;
    end
  end

  // read stage: waits on the registered store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q       <= res;
      s1_read_q  <= is_read;
      s1_rd_ok_q <= rd_ok;
    end
  end

  // merge read data into the result
  always_comb begin
    s1_out = s1_q;
    if (s1_read_q) begin
      s1_out.data_byte = s1_rd_ok_q ? store_rdata : 8'h00;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_vld_q) begin
      out_q <= s1_out;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // checks on the receive logic
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.we |-> (state_q == fpr_pkg::RX_BUSY))
    else $error("store write outside a packet");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(wpos_q) <= fpr_pkg::MAX_LEN)
    else $error("write position beyond row size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpr_pkg::RX_IDLE) |-> (wpos_q == '0))
    else $error("write position not reset while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.clr |=> !fin_q[$past(req.clr_row)])
    else $error("finished flag survives a header");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !s1_adv) |=> (s1_vld_q && $stable(s1_q)))
    else $error("read stage lost while stalled");

endmodule
